// ===== rtl/core/chi_pkg.sv =====
// Shared types, constants and width helpers for the cubic Hermite interpolator.
`timescale 1ns / 1ps
`default_nettype none

package chi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_WIDTH = 32;
   localparam int T_WIDTH   = 17;

   localparam logic ACTION_VALUE = 1'b0;
   localparam logic ACTION_DERIV = 1'b1;

   localparam logic signed [VAL_WIDTH-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_WIDTH-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] start_value;
      logic signed [VAL_WIDTH-1:0] end_value;
      logic signed [VAL_WIDTH-1:0] start_tangent;
      logic signed [VAL_WIDTH-1:0] end_tangent;
      logic        [T_WIDTH-1:0]   param_t;
      logic signed [VAL_WIDTH-1:0] tangent_scale;
      logic                        action;
   } req_type;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] result_value;
      logic                        saturated;
   } rsp_type;

   function automatic int basis_width(input int frac_bits);
      return ((frac_bits > T_WIDTH) ? frac_bits : T_WIDTH) + 4;
   endfunction

   function automatic int blend_width(input int frac_bits);
      return basis_width(frac_bits) + VAL_WIDTH + 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chi_basis.sv =====
// Pipeline stages one to three: parameter clamp, powers of t and the Hermite basis.
`timescale 1ns / 1ps
`default_nettype none

module chi_basis #(
   parameter int FRAC_BITS = chi_pkg::FRAC_BITS
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_stall,
   input  chi_pkg::req_type                                   in_data,
   output logic                                               out_valid,
   input  logic                                               out_stall,
   output chi_pkg::req_type                                   out_data,
   output logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b00,
   output logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b01,
   output logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b10,
   output logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b11
);
   import chi_pkg::*;

   localparam int BW  = basis_width(FRAC_BITS);
   localparam int SQW = 2 * T_WIDTH + 1;

   localparam logic [31:0]           ONE_WIDE = 32'd1 << FRAC_BITS;
   localparam logic [SQW-1:0]        HALF     = SQW'(1) << (FRAC_BITS - 1);
   localparam logic signed [BW-1:0] ONE_B    = BW'(1) << FRAC_BITS;
   localparam logic signed [BW-1:0] K2       = BW'(2);
   localparam logic signed [BW-1:0] K3       = BW'(3);
   localparam logic signed [BW-1:0] K4       = BW'(4);
   localparam logic signed [BW-1:0] K6       = BW'(6);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_stall, s2_stall, s3_stall;

   logic [T_WIDTH-1:0] t_clamp, t2_in, t3_in;
   logic [T_WIDTH-1:0] s1_t_ff, s1_t2_ff;
   logic [T_WIDTH-1:0] s2_t_ff, s2_t2_ff, s2_t3_ff;
   logic [SQW-1:0]     square, cube;

   req_type s1_req_ff, s2_req_ff, s3_req_ff;

   logic signed [BW-1:0] te, t2e, t3e;
   logic signed [BW-1:0] b00_in, b01_in, b10_in, b11_in;
   logic signed [BW-1:0] b00_ff, b01_ff, b10_ff, b11_ff;

   assign s3_stall = s3_valid_ff & out_stall;
   assign s2_stall = s2_valid_ff & s3_stall;
   assign s1_stall = s1_valid_ff & s2_stall;
   assign in_stall = s1_stall;

   always_comb begin
      t_clamp = (32'(in_data.param_t) > ONE_WIDE) ? ONE_WIDE[T_WIDTH-1:0]
                                                  : in_data.param_t;
      square  = SQW'(t_clamp) * SQW'(t_clamp) + HALF;
      t2_in   = T_WIDTH'(square >> FRAC_BITS);
      cube    = SQW'(s1_t2_ff) * SQW'(s1_t_ff) + HALF;
      t3_in   = T_WIDTH'(cube >> FRAC_BITS);
   end

   always_comb begin
      te  = signed'(BW'(s2_t_ff));
      t2e = signed'(BW'(s2_t2_ff));
      t3e = signed'(BW'(s2_t3_ff));
      if (s2_req_ff.action == ACTION_DERIV) begin
         b00_in = K6 * t2e - K6 * te;
         b01_in = -b00_in;
         b10_in = K3 * t2e - K4 * te + ONE_B;
         b11_in = K3 * t2e - K2 * te;
      end else begin
         b00_in = K2 * t3e - K3 * t2e + ONE_B;
         b01_in = ONE_B - b00_in;
         b10_in = t3e - K2 * t2e + te;
         b11_in = t3e - t2e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (!s1_stall) s1_valid_ff <= in_valid;
         if (!s2_stall) s2_valid_ff <= s1_valid_ff;
         if (!s3_stall) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         s1_req_ff <= in_data;
         s1_t_ff   <= t_clamp;
         s1_t2_ff  <= t2_in;
      end
      if (!s2_stall) begin
         s2_req_ff <= s1_req_ff;
         s2_t_ff   <= s1_t_ff;
         s2_t2_ff  <= s1_t2_ff;
         s2_t3_ff  <= t3_in;
      end
      if (!s3_stall) begin
         s3_req_ff <= s2_req_ff;
         b00_ff    <= b00_in;
         b01_ff    <= b01_in;
         b10_ff    <= b10_in;
         b11_ff    <= b11_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_req_ff;
   assign b00       = b00_ff;
   assign b01       = b01_ff;
   assign b10       = b10_ff;
   assign b11       = b11_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chi_blend.sv =====
// Pipeline stages four and five: basis products and the point and tangent sums.
`timescale 1ns / 1ps
`default_nettype none

module chi_blend #(
   parameter int FRAC_BITS = chi_pkg::FRAC_BITS
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_stall,
   input  chi_pkg::req_type                                   in_data,
   input  logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b00,
   input  logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b01,
   input  logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b10,
   input  logic signed [chi_pkg::basis_width(FRAC_BITS)-1:0] b11,
   output logic                                               out_valid,
   input  logic                                               out_stall,
   output logic signed [chi_pkg::blend_width(FRAC_BITS)-1:0] point_sum,
   output logic signed [chi_pkg::blend_width(FRAC_BITS)-1:0] tangent_sum,
   output logic signed [chi_pkg::VAL_WIDTH-1:0]              scale
);
   import chi_pkg::*;

   localparam int BW  = basis_width(FRAC_BITS);
   localparam int PRW = BW + VAL_WIDTH;
   localparam int PW  = blend_width(FRAC_BITS);

   logic s4_valid_ff, s5_valid_ff;
   logic s4_stall, s5_stall;

   logic signed [PRW-1:0]       s4_p00_ff, s4_p01_ff, s4_p10_ff, s4_p11_ff;
   logic signed [VAL_WIDTH-1:0] s4_scale_ff, s5_scale_ff;
   logic signed [PW-1:0]        pv_in, mv_in, s5_pv_ff, s5_mv_ff;

   assign s5_stall = s5_valid_ff & out_stall;
   assign s4_stall = s4_valid_ff & s5_stall;
   assign in_stall = s4_stall;

   assign pv_in = PW'(s4_p00_ff) + PW'(s4_p01_ff);
   assign mv_in = PW'(s4_p10_ff) + PW'(s4_p11_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (!s4_stall) s4_valid_ff <= in_valid;
         if (!s5_stall) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s4_stall) begin
         s4_p00_ff   <= PRW'(b00) * PRW'(in_data.start_value);
         s4_p01_ff   <= PRW'(b01) * PRW'(in_data.end_value);
         s4_p10_ff   <= PRW'(b10) * PRW'(in_data.start_tangent);
         s4_p11_ff   <= PRW'(b11) * PRW'(in_data.end_tangent);
         s4_scale_ff <= in_data.tangent_scale;
      end
      if (!s5_stall) begin
         s5_pv_ff    <= pv_in;
         s5_mv_ff    <= mv_in;
         s5_scale_ff <= s4_scale_ff;
      end
   end

   assign out_valid   = s5_valid_ff;
   assign point_sum   = s5_pv_ff;
   assign tangent_sum = s5_mv_ff;
   assign scale       = s5_scale_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chi_accum.sv =====
// Pipeline stages six to eight: tangent scaling, rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none

module chi_accum #(
   parameter int FRAC_BITS = chi_pkg::FRAC_BITS
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_stall,
   input  logic signed [chi_pkg::blend_width(FRAC_BITS)-1:0] point_sum,
   input  logic signed [chi_pkg::blend_width(FRAC_BITS)-1:0] tangent_sum,
   input  logic signed [chi_pkg::VAL_WIDTH-1:0]              scale,
   output logic                                               out_valid,
   input  logic                                               out_stall,
   output chi_pkg::rsp_type                                   out_data
);
   import chi_pkg::*;

   localparam int PW      = blend_width(FRAC_BITS);
   localparam int LO_BITS = 30;
   localparam int HW      = PW - LO_BITS;
   localparam int LPW     = LO_BITS + 1 + VAL_WIDTH;
   localparam int HPW     = HW + VAL_WIDTH;
   localparam int AW      = PW + VAL_WIDTH + 2;
   localparam int SH      = 2 * FRAC_BITS;

   localparam logic signed [AW-1:0] RND = AW'(1) << (SH - 1);

   logic s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic s6_stall, s7_stall, s8_stall;

   logic signed [LO_BITS:0]     mv_lo;
   logic signed [HW-1:0]        mv_hi;
   logic signed [LPW-1:0]       s6_plo_ff;
   logic signed [HPW-1:0]       s6_phi_ff, s7_phi_ff;
   logic signed [PW-1:0]        s6_pv_ff;
   logic signed [AW-1:0]        part_in, s7_part_ff, acc;
   logic [AW-SH-32:0]           top_bits;
   logic                        in_range;
   rsp_type                     rsp_in, s8_rsp_ff;

   assign s8_stall = s8_valid_ff & out_stall;
   assign s7_stall = s7_valid_ff & s8_stall;
   assign s6_stall = s6_valid_ff & s7_stall;
   assign in_stall = s6_stall;

   assign mv_lo = signed'({1'b0, tangent_sum[LO_BITS-1:0]});
   assign mv_hi = tangent_sum[PW-1:LO_BITS];

   assign part_in = (AW'(s6_pv_ff) <<< FRAC_BITS) + AW'(s6_plo_ff) + RND;

   always_comb begin
      acc      = s7_part_ff + (AW'(s7_phi_ff) <<< LO_BITS);
      top_bits = acc[AW-1:SH+31];
      in_range = (&top_bits) | ~(|top_bits);
      rsp_in.saturated = ~in_range;
      if (in_range) begin
         rsp_in.result_value = acc[SH+31:SH];
      end else begin
         rsp_in.result_value = acc[AW-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         if (!s6_stall) s6_valid_ff <= in_valid;
         if (!s7_stall) s7_valid_ff <= s6_valid_ff;
         if (!s8_stall) s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s6_stall) begin
         s6_plo_ff <= LPW'(mv_lo) * LPW'(scale);
         s6_phi_ff <= HPW'(mv_hi) * HPW'(scale);
         s6_pv_ff  <= point_sum;
      end
      if (!s7_stall) begin
         s7_part_ff <= part_in;
         s7_phi_ff  <= s6_phi_ff;
      end
      if (!s8_stall) begin
         s8_rsp_ff <= rsp_in;
      end
   end

   assign out_valid = s8_valid_ff;
   assign out_data  = s8_rsp_ff;

   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      (s8_valid_ff && s8_rsp_ff.saturated) |->
         (s8_rsp_ff.result_value == SAT_MIN || s8_rsp_ff.result_value == SAT_MAX))
      else $error("saturated result is not a range limit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s6_valid_ff && !s7_valid_ff && !s8_valid_ff))
      else $error("pipeline holds a request after reset");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s7_valid_ff && !s8_stall) |=> s8_valid_ff)
      else $error("request lost between accumulate and output stages");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s8_valid_ff && out_stall && s7_valid_ff) |=> $stable(s7_part_ff))
      else $error("accumulate stage changed while the output stage was stalled");

endmodule

`default_nettype wire

// ===== rtl/core/cubic_hermite_interpolator_core.sv =====
// Top level of the pipelined cubic Hermite segment evaluator.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates one component of a cubic Hermite segment per request, giving either the
// interpolated value or its derivative in t, rounded and saturated to the value format.
// The block takes one request every clock while no stall holds the request side, and
// returns each result through the eight-stage multiplier pipeline; every stage has its
// own valid bit, so empty stages fill while the output is stalled and a stall only
// reaches the request side once the pipeline is full.
module cubic_hermite_interpolator_core #(
   parameter int FRAC_BITS = chi_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chi_pkg::rsp_type rsp_data
);
   import chi_pkg::*;

   localparam int BW = basis_width(FRAC_BITS);
   localparam int PW = blend_width(FRAC_BITS);

   logic                        basis_valid, basis_stall;
   req_type                     basis_req;
   logic signed [BW-1:0]        b00, b01, b10, b11;
   logic                        blend_valid, blend_stall;
   logic signed [PW-1:0]        point_sum, tangent_sum;
   logic signed [VAL_WIDTH-1:0] scale;

   chi_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (basis_valid),
      .out_stall (basis_stall),
      .out_data  (basis_req),
      .b00       (b00),
      .b01       (b01),
      .b10       (b10),
      .b11       (b11)
   );

   chi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (basis_valid),
      .in_stall    (basis_stall),
      .in_data     (basis_req),
      .b00         (b00),
      .b01         (b01),
      .b10         (b10),
      .b11         (b11),
      .out_valid   (blend_valid),
      .out_stall   (blend_stall),
      .point_sum   (point_sum),
      .tangent_sum (tangent_sum),
      .scale       (scale)
   );

   chi_accum #(.FRAC_BITS(FRAC_BITS)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (blend_valid),
      .in_stall    (blend_stall),
      .point_sum   (point_sum),
      .tangent_sum (tangent_sum),
      .scale       (scale),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_data    (rsp_data)
   );

endmodule

`default_nettype wire
